// File: rtl/core/stb_pkg.sv
package stb_pkg;

  // command codes carried in the action field
  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_ABORT  = 3'd1;
  localparam logic [2:0] ACT_ONCE   = 3'd2;
  localparam logic [2:0] ACT_REPEAT = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;

  // configuration register indexes
  localparam logic CFG_PERIOD_0 = 1'b0;
  localparam logic CFG_PERIOD_1 = 1'b1;

  localparam int unsigned PERIOD_W = 16;
  localparam logic [PERIOD_W-1:0] PERIOD_0_RST = 16'd15000;
  localparam logic [PERIOD_W-1:0] PERIOD_1_RST = 16'd12000;

  // one-hot command strobe for a single timer
  typedef struct packed {
    logic tick;
    logic abort;
    logic start_once;
    logic start_rep;
    logic read;
  } stb_cmd_t;

  typedef struct packed {
    logic flag;
    logic running;
  } stb_stat_t;

endpackage

// File: rtl/core/stb_timer.sv
module stb_timer import stb_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  stb_cmd_t            cmd_i,
  input  logic [PERIOD_W-1:0] period_i,
  output stb_stat_t           stat_o,   // current state
  output stb_stat_t           nxt_o     // state after this cycle's command
);

  localparam int CMP_W = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;

  localparam logic [1:0] MODE_STOPPED = 2'd0;
  localparam logic [1:0] MODE_ONCE    = 2'd1;
  localparam logic [1:0] MODE_REPEAT  = 2'd2;

  logic [1:0]             mode_r, mode_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   flag_r, flag_nxt;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic                   expire;

  // count wraps at its own width, compare at the wider of the two
  assign count_inc = count_r + 1'b1;
  assign expire    = (CMP_W'(count_inc) >= CMP_W'(period_i));

  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    flag_nxt  = flag_r;
    if (cmd_i.tick) begin
      if (mode_r == MODE_STOPPED) begin
        count_nxt = '0;
      end else if (!flag_r) begin
        if (expire) begin
          flag_nxt  = 1'b1;
          count_nxt = '0;
          if (mode_r == MODE_ONCE) begin
            mode_nxt = MODE_STOPPED;
          end
        end else begin
          count_nxt = count_inc;
        end
      end
    end else if (cmd_i.abort) begin
      mode_nxt = MODE_STOPPED;
    end else if (cmd_i.start_once || cmd_i.start_rep) begin
      if (mode_r == MODE_STOPPED) begin
        count_nxt = '0;
        mode_nxt  = cmd_i.start_once ? MODE_ONCE : MODE_REPEAT;
      end
    end else if (cmd_i.read) begin
      flag_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_STOPPED;
      count_r <= '0;
      flag_r  <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      flag_r  <= flag_nxt;
    end
  end

  assign stat_o.flag    = flag_r;
  assign stat_o.running = (mode_r != MODE_STOPPED);
  assign nxt_o.flag     = flag_nxt;
  assign nxt_o.running  = (mode_nxt != MODE_STOPPED);

endmodule

// File: rtl/core/soft_timer_bank.sv
// Bank of software timers, each stopped, one-shot or repeating, with a tick
// counter and a sticky expiry flag. Each input beat is one command: tick
// (advances every running timer whose flag is clear), abort, start one-shot,
// start repeating (start only acts on a stopped timer) or read-and-clear of a
// timer's flag. Every command yields exactly one result beat carrying the
// read flag (zero for anything but a read) plus the expiry and running masks
// of timers 0 and 1 after the command. Throughput is one command per clock
// unless out_tready stalls it, and each result is registered in the output
// register. All timers update in parallel with one increment and compare
// each, and the output register is the only buffer: in_tready stays high
// while that register is empty or being drained in the same cycle. Periods
// of timers 0 and 1 come from the config registers (reset 15000 and 12000);
// any further timers run with period zero. Config writes are taken every
// cycle and should only be issued while the bank is idle.
module soft_timer_bank import stb_pkg::*; #(
  parameter int TIMER_COUNT = 2,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // command channel
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [2:0] action, [3] timer_index, [7:4] zero
  // result channel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,  // [0] flag_value, [2:1] pending_flags,
                                          // [4:3] running_mask, [7:5] zero
  // config write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [PERIOD_W-1:0] cfg_data
);

  localparam int MASK_W = 2;

  logic [2:0] action;
  logic       timer_index;
  logic       in_beat;

  assign action      = in_tdata[2:0];
  assign timer_index = in_tdata[3];
  assign in_beat     = in_tvalid && in_tready;

  // ---------------------------------------------------------------- config
  logic [PERIOD_W-1:0] period0_r, period1_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period0_r <= PERIOD_0_RST;
      period1_r <= PERIOD_1_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_PERIOD_0) begin
        period0_r <= cfg_data;
      end else if (cfg_index == CFG_PERIOD_1) begin
        period1_r <= cfg_data;
      end
    end
  end

  // ---------------------------------------------------------------- decode
  stb_cmd_t base_cmd;

  always_comb begin
    base_cmd = '0;
    if (in_beat) begin
      case (action)
        ACT_TICK:   base_cmd.tick       = 1'b1;
        ACT_ABORT:  base_cmd.abort      = 1'b1;
        ACT_ONCE:   base_cmd.start_once = 1'b1;
        ACT_REPEAT: base_cmd.start_rep  = 1'b1;
        ACT_READ:   base_cmd.read       = 1'b1;
        default:    base_cmd            = '0;  // unused codes: no-op
      endcase
    end
  end

  // ---------------------------------------------------------------- timers
  logic [TIMER_COUNT-1:0] hit;       // timer addressed by timer_index
  logic [TIMER_COUNT-1:0] flag_cur;
  logic [TIMER_COUNT-1:0] flag_nxt;
  logic [TIMER_COUNT-1:0] run_cur;
  logic [TIMER_COUNT-1:0] run_nxt;

  for (genvar i = 0; i < TIMER_COUNT; i++) begin : g_timer
    stb_cmd_t            cmd;
    stb_stat_t           stat, nxt;
    logic [PERIOD_W-1:0] period;

    // only timers 0 and 1 can be addressed or configured
    if (i == 0) begin : g_t0
      assign hit[i] = (timer_index == 1'b0);
      assign period = period0_r;
    end else if (i == 1) begin : g_t1
      assign hit[i] = (timer_index == 1'b1);
      assign period = period1_r;
    end else begin : g_tn
      assign hit[i] = 1'b0;
      assign period = '0;
    end

    assign cmd.tick       = base_cmd.tick;
    assign cmd.abort      = base_cmd.abort      && hit[i];
    assign cmd.start_once = base_cmd.start_once && hit[i];
    assign cmd.start_rep  = base_cmd.start_rep  && hit[i];
    assign cmd.read       = base_cmd.read       && hit[i];

    stb_timer #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_timer (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd_i   (cmd),
      .period_i(period),
      .stat_o  (stat),
      .nxt_o   (nxt)
    );

    assign flag_cur[i] = stat.flag;
    assign run_cur[i]  = stat.running;
    assign flag_nxt[i] = nxt.flag;
    assign run_nxt[i]  = nxt.running;
  end

  // masks show timers 0 and 1 only
  logic [MASK_W-1:0] pend_mask, run_mask;

  for (genvar m = 0; m < MASK_W; m++) begin : g_mask
    if (m < TIMER_COUNT) begin : g_on
      assign pend_mask[m] = flag_nxt[m];
      assign run_mask[m]  = run_nxt[m];
    end else begin : g_off
      assign pend_mask[m] = 1'b0;
      assign run_mask[m]  = 1'b0;
    end
  end

  logic read_flag;
  assign read_flag = base_cmd.read && |(flag_cur & hit);

  // ---------------------------------------------------------------- output
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [4:0]          out_data_r;

  assign in_tready      = !out_tvalid_r || out_tready;
  assign out_tvalid_nxt = in_beat || (out_tvalid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      out_data_r <= {run_mask, pend_mask, read_flag};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_data_r};

  // ---------------------------------------------------------------- checks
  // a non-read command never reports a flag
  a_flag_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && action != ACT_READ) |=> !out_tdata[0])
    else $error("flag_value set for a non-read command");

  // expiry flags only rise on a tick
  a_flag_rise_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !base_cmd.tick |=> ((flag_cur & ~$past(flag_cur)) == '0))
    else $error("expiry flag set without a tick");

  // a timer only starts running on a start command
  a_run_rise_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    !(base_cmd.start_once || base_cmd.start_rep)
      |=> ((run_cur & ~$past(run_cur)) == '0))
    else $error("timer started without a start command");

endmodule

// File: dv/tb_soft_timer_bank.sv
module tb_soft_timer_bank import stb_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // unused command codes, the block must leave all state alone
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

  // receiver-side windows, counted in receiver cycles
  localparam int unsigned HOLD_START = 600;   // long back-pressure stretch
  localparam int unsigned HOLD_LEN   = 60;
  localparam int unsigned CALM_START = 1200;  // neither side idles here
  localparam int unsigned CALM_END   = 1500;

  localparam int RAND_PHASES    = 10;
  localparam int RAND_PER_PHASE = 132;

  // period pairs per random phase; extremes first, then mostly small periods
  // so that expiries, frozen counts and one-shot stops happen often
  localparam logic [15:0] PHASE_P0 [RAND_PHASES] =
    '{16'd0, 16'd65535, 16'd3, 16'd1, 16'd7, 16'd0, 16'd12, 16'd2, 16'd5, 16'd65535};
  localparam logic [15:0] PHASE_P1 [RAND_PHASES] =
    '{16'd65535, 16'd0, 16'd5, 16'd2, 16'd4, 16'd0, 16'd9, 16'd2, 16'd1, 16'd65535};

  typedef enum logic [1:0] {T_STOPPED, T_ONCE, T_REPEAT} tmode_t;

  typedef struct packed {
    logic       flag;
    logic [1:0] pend;
    logic [1:0] run;
  } bank_status_t;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

  // one directed step: a command beat or a period write (sel = timer or register)
  typedef struct packed {
    row_kind_t    kind;
    logic [2:0]   act;
    logic         sel;
    logic [15:0]  value;
    logic         typed;  // 1: want holds the expected status, 0: use predictor
    bank_status_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 28;

  // want = {flag, pending mask, running mask}
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // fresh out of reset: nothing pending, nothing running
    '{ROW_CMD, ACT_READ,      1'b0, 16'd0,     1'b1, '{1'b0, 2'd0, 2'd0}},
    '{ROW_CMD, ACT_TICK,      1'b0, 16'd0,     1'b1, '{1'b0, 2'd0, 2'd0}},
    '{ROW_CMD, ACT_ONCE,      1'b0, 16'd0,     1'b1, '{1'b0, 2'd0, 2'd1}},
    '{ROW_CMD, ACT_REPEAT,    1'b1, 16'd0,     1'b1, '{1'b0, 2'd0, 2'd3}},
    // start on a running timer is ignored
    '{ROW_CMD, ACT_REPEAT,    1'b0, 16'd0,     1'b1, '{1'b0, 2'd0, 2'd3}},
    '{ROW_CMD, ACT_ONCE,      1'b1, 16'd0,     1'b1, '{1'b0, 2'd0, 2'd3}},
    '{ROW_CMD, ACT_UNUSED_LO, 1'b0, 16'd0,     1'b1, '{1'b0, 2'd0, 2'd3}},
    '{ROW_CMD, ACT_UNUSED_HI, 1'b1, 16'd0,     1'b1, '{1'b0, 2'd0, 2'd3}},
    // period zero: one-shot timer 0 fires and stops on its first tick
    '{ROW_CFG, ACT_TICK,      CFG_PERIOD_0, 16'd0, 1'b0, '{1'b0, 2'd0, 2'd0}},
    '{ROW_CMD, ACT_TICK,      1'b0, 16'd0,     1'b1, '{1'b0, 2'd1, 2'd2}},
    '{ROW_CMD, ACT_TICK,      1'b0, 16'd0,     1'b1, '{1'b0, 2'd1, 2'd2}},
    // period below the current count of timer 1: fires on the next tick
    '{ROW_CFG, ACT_TICK,      CFG_PERIOD_1, 16'd1, 1'b0, '{1'b0, 2'd0, 2'd0}},
    '{ROW_CMD, ACT_TICK,      1'b0, 16'd0,     1'b1, '{1'b0, 2'd3, 2'd2}},
    // flag set on a running timer freezes its count
    '{ROW_CMD, ACT_TICK,      1'b0, 16'd0,     1'b1, '{1'b0, 2'd3, 2'd2}},
    '{ROW_CMD, ACT_READ,      1'b1, 16'd0,     1'b1, '{1'b1, 2'd1, 2'd2}},
    '{ROW_CMD, ACT_READ,      1'b1, 16'd0,     1'b1, '{1'b0, 2'd1, 2'd2}},
    '{ROW_CMD, ACT_TICK,      1'b0, 16'd0,     1'b1, '{1'b0, 2'd3, 2'd2}},
    '{ROW_CMD, ACT_ABORT,     1'b1, 16'd0,     1'b1, '{1'b0, 2'd3, 2'd0}},
    '{ROW_CMD, ACT_READ,      1'b0, 16'd0,     1'b1, '{1'b1, 2'd2, 2'd0}},
    '{ROW_CMD, ACT_ABORT,     1'b0, 16'd0,     1'b1, '{1'b0, 2'd2, 2'd0}},
    '{ROW_CMD, ACT_READ,      1'b1, 16'd0,     1'b1, '{1'b1, 2'd0, 2'd0}},
    // largest periods
    '{ROW_CFG, ACT_TICK,      CFG_PERIOD_0, 16'd65535, 1'b0, '{1'b0, 2'd0, 2'd0}},
    '{ROW_CFG, ACT_TICK,      CFG_PERIOD_1, 16'd65535, 1'b0, '{1'b0, 2'd0, 2'd0}},
    '{ROW_CMD, ACT_ONCE,      1'b0, 16'd0,     1'b1, '{1'b0, 2'd0, 2'd1}},
    '{ROW_CMD, ACT_REPEAT,    1'b1, 16'd0,     1'b1, '{1'b0, 2'd0, 2'd3}},
    '{ROW_CMD, ACT_TICK,      1'b0, 16'd0,     1'b0, '{1'b0, 2'd0, 2'd0}},
    '{ROW_CMD, ACT_ABORT,     1'b0, 16'd0,     1'b0, '{1'b0, 2'd0, 2'd0}},
    '{ROW_CMD, ACT_ABORT,     1'b1, 16'd0,     1'b0, '{1'b0, 2'd0, 2'd0}}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = '0;   // [2:0] action, [3] timer_index, [7:4] zero
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [7:0]          out_tdata;       // [0] flag_value, [2:1] pending_flags,
                                        // [4:3] running_mask, [7:5] zero
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_index = 1'b0;
  logic [PERIOD_W-1:0] cfg_data = '0;

  int unsigned cyc = 0;
  int          fail_cnt = 0;

  // shadow copy of the timer bank
  tmode_t      t_mode   [2];
  logic [15:0] t_count  [2];
  logic [15:0] t_period [2];
  logic [1:0]  t_flag;

  // status beats still owed by the block, oldest first
  bank_status_t status_q [$];

  soft_timer_bank u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one command to the shadow bank; return the status the block must report.
  function automatic bank_status_t step_bank(input logic [2:0] act, input logic sel);
    bank_status_t st;
    logic [15:0]  nxt;
    st = '0;
    case (act)
      ACT_TICK: begin
        for (int i = 0; i < 2; i++) begin
          if (t_mode[i] == T_STOPPED) begin
            t_count[i] = '0;
          end else if (!t_flag[i]) begin
            nxt = t_count[i] + 16'd1;  // wraps at the count width
            if (nxt >= t_period[i]) begin
              t_flag[i]  = 1'b1;
              t_count[i] = '0;
              if (t_mode[i] == T_ONCE) t_mode[i] = T_STOPPED;
            end else begin
              t_count[i] = nxt;
            end
          end
        end
      end
      ACT_ABORT: t_mode[sel] = T_STOPPED;
      ACT_ONCE, ACT_REPEAT: begin
        if (t_mode[sel] == T_STOPPED) begin
          t_count[sel] = '0;
          t_mode[sel]  = (act == ACT_ONCE) ? T_ONCE : T_REPEAT;
        end
      end
      ACT_READ: begin
        st.flag     = t_flag[sel];
        t_flag[sel] = 1'b0;
      end
      default: ;
    endcase
    for (int i = 0; i < 2; i++) begin
      st.pend[i] = t_flag[i];
      st.run[i]  = (t_mode[i] != T_STOPPED);
    end
    return st;
  endfunction

  // random sender gaps, except inside the calm window
  task automatic maybe_idle();
    while ((cyc < CALM_START || cyc >= CALM_END) && $urandom_range(0, 99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Offer one command beat and hold it until taken. Valid stays high on return.
  task automatic send_cmd(input logic [2:0] act, input logic sel,
                          input logic typed, input bank_status_t want);
    bank_status_t predicted;
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, sel, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = step_bank(act, sel);
    status_q.push_back(typed ? want : predicted);
  endtask

  // stop offering and wait until every owed status beat is back
  task automatic drain_bank();
    in_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);  // margin past the output register
  endtask

  // period writes only while the bank is idle
  task automatic write_period(input logic idx, input logic [15:0] val);
    drain_bank();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    t_period[idx] = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random stalls, one long hold-off to back the block up, one calm stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      cyc <= cyc + 1;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
        out_tready <= 1'b0;
      end else if (cyc >= CALM_START && cyc < CALM_END) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // result checker: each beat against the oldest owed status
  always @(posedge clk) begin : chk
    bank_status_t got;
    bank_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.flag = out_tdata[0];
      got.pend = out_tdata[2:1];
      got.run  = out_tdata[4:3];
      if (status_q.size() == 0) begin
        fail_cnt++;
        $display("%0t: result beat with nothing owed: flag %0d pend %b run %b",
                 $realtime, got.flag, got.pend, got.run);
      end else begin
        want = status_q.pop_front();
        if (got.flag !== want.flag || got.pend !== want.pend || got.run !== want.run) begin
          fail_cnt++;
          $display("%0t: expected flag %0d pend %b run %b, got flag %0d pend %b run %b",
                   $realtime, want.flag, want.pend, want.run, got.flag, got.pend, got.run);
        end
      end
    end
  end

  initial begin : stim
    logic [2:0] act;
    int         pick;
    int         issued;

    for (int i = 0; i < 2; i++) begin
      t_mode[i]  = T_STOPPED;
      t_count[i] = '0;
    end
    t_flag      = '0;
    t_period[0] = PERIOD_0_RST;
    t_period[1] = PERIOD_1_RST;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        write_period(DIRECTED[r].sel, DIRECTED[r].value);
      end else begin
        maybe_idle();
        send_cmd(DIRECTED[r].act, DIRECTED[r].sel, DIRECTED[r].typed, DIRECTED[r].want);
      end
    end

    // random phases, one period setting each; unused codes do not count
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_period(CFG_PERIOD_0, PHASE_P0[ph]);
      write_period(CFG_PERIOD_1, PHASE_P1[ph]);
      issued = 0;
      while (issued < RAND_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)      act = ACT_TICK;
        else if (pick < 55) act = ACT_ONCE;
        else if (pick < 65) act = ACT_REPEAT;
        else if (pick < 82) act = ACT_READ;
        else if (pick < 92) act = ACT_ABORT;
        else                act = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        maybe_idle();
        send_cmd(act, 1'($urandom_range(0, 1)), 1'b0, '0);
        if (act <= ACT_READ) issued++;
      end
    end

    drain_bank();
    repeat (2) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("soft_timer_bank: match");
    end else begin
      $display("soft_timer_bank: mismatch");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("soft_timer_bank: mismatch");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/stb_pkg.sv
rtl/core/stb_timer.sv
rtl/core/soft_timer_bank.sv
dv/tb_soft_timer_bank.sv
